/* design/cip_pkg.sv */
// Shared types, constants and helpers for the complex integer power block.
package cip_pkg;

  localparam int DATA_W           = 32;
  localparam int EXP_W            = 9;
  localparam int DEF_MAX_EXPONENT = 255;
  localparam int DEF_FRAC_BITS    = 16;
  localparam int QUO_W            = 34;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ONE,
    OP_ZERO,
    OP_COPY,
    OP_SQ,
    OP_DEN,
    OP_DIV,
    OP_FIX,
    OP_MUL,
    OP_ACC,
    OP_OUT
  } cip_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_DEN,
    S_DIV,
    S_FIX,
    S_MUL,
    S_ACC,
    S_DONE
  } cip_state_t;

  typedef struct packed {
    cip_op_t op;
  } cip_cmd_t;

  typedef struct packed {
    logic zero_exp;
    logic dz;
    logic neg;
    logic div_last;
    logic cnt_zero;
  } cip_status_t;

  typedef struct packed {
    logic              sat;
    logic [DATA_W-1:0] val;
  } clamp_t;

  // clamp a wide signed value to the 32-bit signed range
  function automatic clamp_t clamp32(input logic signed [65:0] v);
    clamp_t r;
    if (v > 66'sh0_7FFF_FFFF) begin
      r.sat = 1'b1;
      r.val = 32'h7FFF_FFFF;
    end else if (v < -66'sh0_8000_0000) begin
      r.sat = 1'b1;
      r.val = 32'h8000_0000;
    end else begin
      r.sat = 1'b0;
      r.val = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // apply sign to a capped quotient magnitude, then clamp
  function automatic clamp_t signed_part(input logic [QUO_W-1:0] q, input logic neg);
    clamp_t r;
    logic [QUO_W-1:0] qc;
    qc = (q > 34'h1_0000_0000) ? 34'h1_0000_0000 : q;
    if (neg) begin
      if (qc > 34'h0_8000_0000) begin
        r.sat = 1'b1;
        r.val = 32'h8000_0000;
      end else begin
        r.sat = 1'b0;
        r.val = 32'(~qc + 34'd1);
      end
    end else begin
      if (qc > 34'h0_7FFF_FFFF) begin
        r.sat = 1'b1;
        r.val = 32'h7FFF_FFFF;
      end else begin
        r.sat = 1'b0;
        r.val = qc[DATA_W-1:0];
      end
    end
    return r;
  endfunction

endpackage

/* design/cip_in_if.sv */
// Input channel: complex base and exponent with valid/ready.
interface cip_in_if import cip_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] base_real;
  logic signed [DATA_W-1:0] base_imag;
  logic signed [EXP_W-1:0]  exponent;

  modport source (output valid, base_real, base_imag, exponent, input ready);
  modport sink (input valid, base_real, base_imag, exponent, output ready);
endinterface

/* design/cip_out_if.sv */
// Output channel: complex power and flags with valid/ready.
interface cip_out_if import cip_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] power_real;
  logic signed [DATA_W-1:0] power_imag;
  logic                     saturated;
  logic                     divide_by_zero;

  modport source (output valid, power_real, power_imag, saturated, divide_by_zero,
                  input ready);
  modport sink (input valid, power_real, power_imag, saturated, divide_by_zero,
                output ready);
endinterface

/* design/cip_datapath.sv */
// Datapath: multipliers, accumulate/clamp, reciprocal divider and result registers.
module cip_datapath import cip_pkg::*; #(
  parameter int MAX_EXPONENT = DEF_MAX_EXPONENT,
  parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
  input  logic                     clk,
  input  cip_cmd_t                 cmd,
  output cip_status_t              status,
  input  logic signed [DATA_W-1:0] base_real,
  input  logic signed [DATA_W-1:0] base_imag,
  input  logic signed [EXP_W-1:0]  exponent,
  output logic signed [DATA_W-1:0] power_real,
  output logic signed [DATA_W-1:0] power_imag,
  output logic                     saturated,
  output logic                     divide_by_zero
);

  localparam int DIV_STEPS = DATA_W + 2 * FRAC_BITS;
  localparam int DCW       = $clog2(DIV_STEPS);

  logic signed [DATA_W-1:0] a, b, zr, zi, pr, pi;
  logic                     neg, dz, zero_exp, sat;
  logic [EXP_W-1:0]         cnt;
  logic signed [63:0]       m0, m1, m2, m3;
  logic [63:0]              den, rr, ri;
  logic [DATA_W-1:0]        xr, xi;
  logic [QUO_W-1:0]         qr, qi;
  logic [DCW-1:0]           dcnt;

  logic [EXP_W-1:0]         mag, magc;
  logic                     e_neg;
  logic [DATA_W-1:0]        ua, ub;
  logic signed [32:0]       x0, y0, x1, y1, x2, y2, x3, y3;
  logic signed [65:0]       p0, p1, p2, p3;
  logic signed [65:0]       sr, si;
  clamp_t                   cr, ci, fr, fi;
  logic [64:0]              tr, ti;
  logic                     ger, gei;

  always_comb begin
    e_neg = exponent[EXP_W-1];
    mag   = e_neg ? (~exponent + 1'b1) : exponent;
    magc  = ({8'd0, mag} > 17'(MAX_EXPONENT)) ? EXP_W'(MAX_EXPONENT) : mag;
    ua    = a[DATA_W-1] ? DATA_W'(-a) : a;
    ub    = b[DATA_W-1] ? DATA_W'(-b) : b;

    if (cmd.op == OP_SQ) begin
      x0 = {1'b0, ua}; y0 = {1'b0, ua};
      x1 = {1'b0, ub}; y1 = {1'b0, ub};
    end else begin
      x0 = 33'(zr); y0 = 33'(pr);
      x1 = 33'(zi); y1 = 33'(pi);
    end
    x2 = 33'(zr); y2 = 33'(pi);
    x3 = 33'(zi); y3 = 33'(pr);
    p0 = 66'(x0) * 66'(y0);
    p1 = 66'(x1) * 66'(y1);
    p2 = 66'(x2) * 66'(y2);
    p3 = 66'(x3) * 66'(y3);

    sr = (66'(m0) - 66'(m1)) >>> FRAC_BITS;
    si = (66'(m2) + 66'(m3)) >>> FRAC_BITS;
    cr = clamp32(sr);
    ci = clamp32(si);

    tr  = {rr, xr[DATA_W-1]};
    ti  = {ri, xi[DATA_W-1]};
    ger = tr >= {1'b0, den};
    gei = ti >= {1'b0, den};

    fr = signed_part(qr, a[DATA_W-1]);
    fi = signed_part(qi, !b[DATA_W-1] && (b != '0));

    status.zero_exp = zero_exp;
    status.dz       = dz;
    status.neg      = neg;
    status.div_last = (dcnt == '0);
    status.cnt_zero = (cnt == '0);
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        a        <= base_real;
        b        <= base_imag;
        neg      <= e_neg;
        zero_exp <= (magc == '0);
        dz       <= e_neg && (magc != '0) && (base_real == '0) && (base_imag == '0);
        cnt      <= magc - 1'b1;
        sat      <= 1'b0;
      end
      OP_ONE: begin
        pr <= DATA_W'(1) << FRAC_BITS;
        pi <= '0;
      end
      OP_ZERO: begin
        pr <= '0;
        pi <= '0;
      end
      OP_COPY: begin
        zr <= a; zi <= b;
        pr <= a; pi <= b;
      end
      OP_SQ, OP_MUL: begin
        m0 <= p0[63:0];
        m1 <= p1[63:0];
        m2 <= p2[63:0];
        m3 <= p3[63:0];
      end
      OP_DEN: begin
        den  <= 64'(m0) + 64'(m1);
        rr   <= '0;
        ri   <= '0;
        qr   <= '0;
        qi   <= '0;
        xr   <= ua;
        xi   <= ub;
        dcnt <= DCW'(DIV_STEPS - 1);
      end
      OP_DIV: begin
        rr   <= ger ? 64'(tr - {1'b0, den}) : tr[63:0];
        ri   <= gei ? 64'(ti - {1'b0, den}) : ti[63:0];
        qr   <= qr[QUO_W-1] ? qr : {qr[QUO_W-2:0], ger};
        qi   <= qi[QUO_W-1] ? qi : {qi[QUO_W-2:0], gei};
        xr   <= {xr[DATA_W-2:0], 1'b0};
        xi   <= {xi[DATA_W-2:0], 1'b0};
        dcnt <= dcnt - 1'b1;
      end
      OP_FIX: begin
        zr  <= fr.val; zi <= fi.val;
        pr  <= fr.val; pi <= fi.val;
        sat <= sat | fr.sat | fi.sat;
      end
      OP_ACC: begin
        pr  <= cr.val;
        pi  <= ci.val;
        cnt <= cnt - 1'b1;
        sat <= sat | cr.sat | ci.sat;
      end
      OP_OUT: begin
        power_real     <= pr;
        power_imag     <= pi;
        saturated      <= sat && !dz && !zero_exp;
        divide_by_zero <= dz;
      end
      default: begin
      end
    endcase
  end

endmodule

/* design/cip_ctrl.sv */
// Controller: sequences load, inversion, multiply loop and output handoff.
module cip_ctrl import cip_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  cip_status_t status,
  output cip_cmd_t    cmd
);

  cip_state_t state, state_next;
  logic       out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_START;
        end
      end
      S_START: begin
        priority if (status.zero_exp) begin
          cmd.op     = OP_ONE;
          state_next = S_DONE;
        end else if (status.dz) begin
          cmd.op     = OP_ZERO;
          state_next = S_DONE;
        end else if (status.neg) begin
          cmd.op     = OP_SQ;
          state_next = S_DEN;
        end else begin
          cmd.op     = OP_COPY;
          state_next = S_MUL;
        end
      end
      S_DEN: begin
        cmd.op     = OP_DEN;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (status.div_last) state_next = S_FIX;
      end
      S_FIX: begin
        cmd.op     = OP_FIX;
        state_next = S_MUL;
      end
      S_MUL: begin
        if (status.cnt_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_MUL;
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.op     = OP_ACC;
        state_next = S_MUL;
      end
      S_DONE: begin
        // hand off once the output register is free
        if (!out_valid || out_ready) begin
          cmd.op     = OP_OUT;
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* design/complex_integer_power_top.sv */
// Top level of the complex integer power block.
//
// One word on in_ch (base_real, base_imag in signed fixed point, exponent
// as a signed integer) gives one word on out_ch (power_real, power_imag,
// saturated, divide_by_zero). Both channels use valid/ready; a word moves
// when both are high.
// A zero exponent gives one and a zero base with a negative exponent gives
// zero, with no multiply loop. A negative exponent first forms the
// reciprocal in a divider (one quotient bit per cycle). The multiply loop
// runs n-1 steps for an exponent of magnitude n; each step forms four
// products (S_MUL), then sums, shifts and clamps them (S_ACC).
// The exponent magnitude is capped at MAX_EXPONENT.
// One word is worked on at a time; in_ch.ready is high only while idle.
// The result sits in an output register, so the next word is taken while
// a finished result still waits on out_ch; if the receiver stalls longer,
// the following result waits in the datapath until the register frees up.
// Synchronous reset returns to idle and drops out_ch.valid.
module complex_integer_power_top import cip_pkg::*; #(
  parameter int MAX_EXPONENT = DEF_MAX_EXPONENT,
  parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
  input  logic clk,
  input  logic rst,
  cip_in_if.sink    in_ch,
  cip_out_if.source out_ch
);

  cip_cmd_t    cmd;
  cip_status_t status;

  cip_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  cip_datapath #(
    .MAX_EXPONENT (MAX_EXPONENT),
    .FRAC_BITS    (FRAC_BITS)
  ) u_datapath (
    .clk            (clk),
    .cmd            (cmd),
    .status         (status),
    .base_real      (in_ch.base_real),
    .base_imag      (in_ch.base_imag),
    .exponent       (in_ch.exponent),
    .power_real     (out_ch.power_real),
    .power_imag     (out_ch.power_imag),
    .saturated      (out_ch.saturated),
    .divide_by_zero (out_ch.divide_by_zero)
  );

endmodule
